/* design/rcdw_pkg.sv */
`default_nettype none
package rcdw_pkg;

   localparam int MAG_W  = 17;
   localparam int PEAK_W = 16;
   localparam int NUM_W  = 33;
   localparam int DEN_W  = 32;
   localparam int REM_W  = 33;
   localparam int QUO_W  = 25;
   localparam int Q30_W  = 31;
   localparam int T_W    = 32;
   localparam int NSTEP  = 6;

   localparam logic [1:0] CSR_SAMPLE_PEAK = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD   = 2'd1;
   localparam logic [1:0] CSR_STRENGTH    = 2'd2;
   localparam logic [1:0] CSR_WIDE_CURVE  = 2'd3;

   localparam logic [24:0]      RECIP_255 = 25'd16843010;
   localparam logic [24:0]      Q24_ONE   = 25'h1000000;
   localparam logic [24:0]      Q24_HALF  = 25'h0800000;
   localparam logic [Q30_W-1:0] Q30_ONE   = 31'h40000000;
   localparam logic [31:0]      PI_Q30    = 32'd3373259426;

   localparam logic [33:0] HORNER_MUL [NSTEP] = '{
      34'(((64'd1 << 40) + 64'd131) / 64'd132),
      34'(((64'd1 << 39) + 64'd89) / 64'd90),
      34'(((64'd1 << 38) + 64'd55) / 64'd56),
      34'(((64'd1 << 37) + 64'd29) / 64'd30),
      34'(((64'd1 << 36) + 64'd11) / 64'd12),
      34'(((64'd1 << 33) + 64'd1) / 64'd2)
   };
   localparam int HORNER_SHIFT [NSTEP] = '{40, 39, 38, 37, 36, 33};

   typedef struct packed {
      logic              thr_zero;
      logic              in_range;
      logic              mag_zero;
      logic [PEAK_W-1:0] str;
      logic [PEAK_W-1:0] peak;
   } rcdw_side_type;

endpackage
`default_nettype wire

/* design/rcdw_scale.sv */
`default_nettype none
module rcdw_scale (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic [rcdw_pkg::MAG_W-1:0]      in_mag,
   input  logic [rcdw_pkg::PEAK_W-1:0]     peak,
   input  logic [7:0]                      thr8,
   input  logic [7:0]                      str8,
   input  logic                            wide,
   output logic                            out_valid,
   output logic [rcdw_pkg::NUM_W-1:0]      out_num,
   output logic [rcdw_pkg::DEN_W-1:0]      out_den,
   output rcdw_pkg::rcdw_side_type         out_side
);
   import rcdw_pkg::*;

   logic              vld_a_ff, vld_b_ff, vld_c_ff, vld_d_ff;
   logic [MAG_W-1:0]  mag_a_ff, mag_b_ff, mag_c_ff;
   logic [PEAK_W-1:0] peak_a_ff, peak_b_ff, peak_c_ff;
   logic              wide_a_ff, wide_b_ff, wide_c_ff;
   logic [23:0]       pt_a_ff, ps_a_ff;
   logic [48:0]       tq_b_ff, sq_b_ff;
   logic [PEAK_W-1:0] thr_c_ff, str_c_ff;
   logic [NUM_W-1:0]  num_d_ff, num_d_in;
   logic [DEN_W-1:0]  den_d_ff, den_d_in;
   rcdw_side_type     side_d_ff, side_d_in;

   always_comb begin
      num_d_in = wide_c_ff ? NUM_W'(34'(mag_c_ff) * 34'(mag_c_ff)) : NUM_W'(mag_c_ff);
      den_d_in = wide_c_ff ? (DEN_W'(thr_c_ff) * DEN_W'(thr_c_ff)) : DEN_W'(thr_c_ff);
      side_d_in.thr_zero = (thr_c_ff == '0);
      side_d_in.in_range = (mag_c_ff <= MAG_W'(thr_c_ff));
      side_d_in.mag_zero = (mag_c_ff == '0);
      side_d_in.str      = str_c_ff;
      side_d_in.peak     = peak_c_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
         vld_b_ff <= 1'b0;
         vld_c_ff <= 1'b0;
         vld_d_ff <= 1'b0;
      end else if (advance) begin
         vld_a_ff <= in_valid;
         vld_b_ff <= vld_a_ff;
         vld_c_ff <= vld_b_ff;
         vld_d_ff <= vld_c_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         mag_a_ff  <= in_mag;
         peak_a_ff <= peak;
         wide_a_ff <= wide;
         pt_a_ff   <= 24'(32'(thr8) * 32'(peak) + 32'd127);
         ps_a_ff   <= 24'(32'(str8) * 32'(peak) + 32'd127);
         mag_b_ff  <= mag_a_ff;
         peak_b_ff <= peak_a_ff;
         wide_b_ff <= wide_a_ff;
         tq_b_ff   <= 49'(pt_a_ff) * 49'(RECIP_255);
         sq_b_ff   <= 49'(ps_a_ff) * 49'(RECIP_255);
         mag_c_ff  <= mag_b_ff;
         peak_c_ff <= peak_b_ff;
         wide_c_ff <= wide_b_ff;
         thr_c_ff  <= tq_b_ff[47:32];
         str_c_ff  <= sq_b_ff[47:32];
         num_d_ff  <= num_d_in;
         den_d_ff  <= den_d_in;
         side_d_ff <= side_d_in;
      end
   end

   assign out_valid = vld_d_ff;
   assign out_num   = num_d_ff;
   assign out_den   = den_d_ff;
   assign out_side  = side_d_ff;

endmodule
`default_nettype wire

/* design/rcdw_div.sv */
`default_nettype none
module rcdw_div (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [rcdw_pkg::NUM_W-1:0]  in_num,
   input  logic [rcdw_pkg::DEN_W-1:0]  in_den,
   input  rcdw_pkg::rcdw_side_type     in_side,
   output logic                        out_valid,
   output logic [rcdw_pkg::QUO_W-1:0]  out_quo,
   output rcdw_pkg::rcdw_side_type     out_side
);
   import rcdw_pkg::*;

   logic              vld_ff  [QUO_W];
   logic [REM_W-1:0]  rem_ff  [QUO_W];
   logic [QUO_W-1:0]  quo_ff  [QUO_W];
   logic [DEN_W-1:0]  den_ff  [QUO_W];
   rcdw_side_type     side_ff [QUO_W];

   for (genvar k = 0; k < QUO_W; k++) begin : g_stage
      logic [REM_W:0]   trial;
      logic [REM_W:0]   diff;
      logic             qbit;
      logic             vld_src;
      logic [QUO_W-1:0] quo_src;
      logic [DEN_W-1:0] den_src;
      rcdw_side_type    side_src;

      if (k == 0) begin : g_first
         assign trial    = {1'b0, in_num};
         assign vld_src  = in_valid;
         assign quo_src  = '0;
         assign den_src  = in_den;
         assign side_src = in_side;
      end else begin : g_next
         assign trial    = {rem_ff[k-1], 1'b0};
         assign vld_src  = vld_ff[k-1];
         assign quo_src  = quo_ff[k-1];
         assign den_src  = den_ff[k-1];
         assign side_src = side_ff[k-1];
      end

      always_comb begin
         qbit = (trial >= (REM_W+1)'(den_src));
         diff = qbit ? (trial - (REM_W+1)'(den_src)) : trial;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (advance) begin
            vld_ff[k] <= vld_src;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[k]  <= diff[REM_W-1:0];
            quo_ff[k]  <= {quo_src[QUO_W-2:0], qbit};
            den_ff[k]  <= den_src;
            side_ff[k] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[QUO_W-1];
   assign out_quo   = quo_ff[QUO_W-1];
   assign out_side  = side_ff[QUO_W-1];

endmodule
`default_nettype wire

/* design/rcdw_cos.sv */
`default_nettype none
module rcdw_cos (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        advance,
   input  logic                        in_valid,
   input  logic [rcdw_pkg::QUO_W-1:0]  in_phase,
   input  rcdw_pkg::rcdw_side_type     in_side,
   output logic                        out_valid,
   output logic [25:0]                 out_q,
   output rcdw_pkg::rcdw_side_type     out_side
);
   import rcdw_pkg::*;

   logic              vld0_ff, vld1_ff, vld2_ff, vldq_ff;
   logic              low0_ff, low1_ff, low2_ff;
   rcdw_side_type     side0_ff, side1_ff, side2_ff, sideq_ff;
   logic [55:0]       prod0_ff;
   logic [61:0]       sq1_ff;
   logic [T_W-1:0]    t2_ff;
   logic              low_in;
   logic [23:0]       fold_in;
   logic [25:0]       q_in;
   logic [25:0]       q_ff;

   logic              va_ff [NSTEP], vb_ff [NSTEP], vc_ff [NSTEP];
   logic              la_ff [NSTEP], lb_ff [NSTEP], lc_ff [NSTEP];
   rcdw_side_type     sa_ff [NSTEP], sb_ff [NSTEP], sc_ff [NSTEP];
   logic [T_W-1:0]    ta_ff [NSTEP], tb_ff [NSTEP], tc_ff [NSTEP];
   logic [62:0]       tr_ff [NSTEP];
   logic [65:0]       xm_ff [NSTEP];
   logic [Q30_W-1:0]  r_ff  [NSTEP];

   always_comb begin
      low_in  = (in_phase <= Q24_HALF);
      fold_in = low_in ? in_phase[23:0] : 24'(Q24_ONE - in_phase);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld0_ff <= 1'b0;
         vld1_ff <= 1'b0;
         vld2_ff <= 1'b0;
      end else if (advance) begin
         vld0_ff <= in_valid;
         vld1_ff <= vld0_ff;
         vld2_ff <= vld1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         low0_ff  <= low_in;
         side0_ff <= in_side;
         prod0_ff <= 56'(fold_in) * 56'(PI_Q30);
         low1_ff  <= low0_ff;
         side1_ff <= side0_ff;
         sq1_ff   <= 62'(prod0_ff[54:24]) * 62'(prod0_ff[54:24]);
         low2_ff  <= low1_ff;
         side2_ff <= side1_ff;
         t2_ff    <= sq1_ff[61:30];
      end
   end

   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      logic             v_src, l_src;
      rcdw_side_type    s_src;
      logic [T_W-1:0]   t_src;
      logic [Q30_W-1:0] r_src;
      logic [33:0]      sub;

      if (k == 0) begin : g_first
         assign v_src = vld2_ff;
         assign l_src = low2_ff;
         assign s_src = side2_ff;
         assign t_src = t2_ff;
         assign r_src = Q30_ONE;
      end else begin : g_next
         assign v_src = vc_ff[k-1];
         assign l_src = lc_ff[k-1];
         assign s_src = sc_ff[k-1];
         assign t_src = tc_ff[k-1];
         assign r_src = r_ff[k-1];
      end

      assign sub = 34'(xm_ff[k] >> HORNER_SHIFT[k]);

      always_ff @(posedge clock) begin
         if (reset) begin
            va_ff[k] <= 1'b0;
            vb_ff[k] <= 1'b0;
            vc_ff[k] <= 1'b0;
         end else if (advance) begin
            va_ff[k] <= v_src;
            vb_ff[k] <= va_ff[k];
            vc_ff[k] <= vb_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            la_ff[k] <= l_src;
            sa_ff[k] <= s_src;
            ta_ff[k] <= t_src;
            tr_ff[k] <= 63'(t_src) * 63'(r_src);
            lb_ff[k] <= la_ff[k];
            sb_ff[k] <= sa_ff[k];
            tb_ff[k] <= ta_ff[k];
            xm_ff[k] <= 66'(tr_ff[k][61:30]) * 66'(HORNER_MUL[k]);
            lc_ff[k] <= lb_ff[k];
            sc_ff[k] <= sb_ff[k];
            tc_ff[k] <= tb_ff[k];
            r_ff[k]  <= (sub > 34'(Q30_ONE)) ? '0 : Q30_W'(34'(Q30_ONE) - sub);
         end
      end
   end

   always_comb begin
      if (lc_ff[NSTEP-1]) begin
         q_in = 26'(Q24_ONE) + 26'(r_ff[NSTEP-1] >> 6);
      end else begin
         q_in = 26'(Q24_ONE) - 26'(r_ff[NSTEP-1] >> 6);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vldq_ff <= 1'b0;
      end else if (advance) begin
         vldq_ff <= vc_ff[NSTEP-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sideq_ff <= sc_ff[NSTEP-1];
         q_ff     <= q_in;
      end
   end

   assign out_valid = vldq_ff;
   assign out_q     = q_ff;
   assign out_side  = sideq_ff;

endmodule
`default_nettype wire

/* design/raised_cosine_diff_weight_core.sv */
// channel  direction  handshake            payload
// req      in         req_valid/req_ready  req_pixel_difference[16:0] signed
// rsp      out        rsp_valid/rsp_ready  rsp_weight[15:0]
// csr      in         csr_write_enable     csr_index[1:0], csr_write_data[15:0]
//
// One word per cycle in and out unless rsp stalls; words pass the 25-stage
// restoring divider and the six three-stage Horner steps of the cosine.
// Reset clears all valid bits and loads the CSR registers with their defaults.
// A stall on rsp freezes the whole pipeline; req_ready drops in the same cycle.
`default_nettype none
module raised_cosine_diff_weight_core #(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [16:0]          req_pixel_difference,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [15:0]                 rsp_weight,
   input  logic                        csr_write_enable,
   input  logic [1:0]                  csr_index,
   input  logic [15:0]                 csr_write_data
);
   import rcdw_pkg::*;

   logic [SAMPLE_BITS-1:0] peak_ff;
   logic [7:0]             thr8_ff, str8_ff;
   logic                   wide_ff;
   logic                   advance;
   logic [MAG_W-1:0]       mag;

   logic                   sc_valid;
   logic [NUM_W-1:0]       sc_num;
   logic [DEN_W-1:0]       sc_den;
   rcdw_side_type          sc_side;
   logic                   div_valid;
   logic [QUO_W-1:0]       div_quo;
   rcdw_side_type          div_side;
   logic                   cos_valid;
   logic [25:0]            cos_q;
   rcdw_side_type          cos_side;

   logic                   fin_vld_ff;
   rcdw_side_type          fin_side_ff;
   logic [40:0]            fin_prod_ff;
   logic                   rsp_valid_ff;
   logic [15:0]            rsp_weight_ff, rsp_weight_in;
   logic [16:0]            curve, wsel;

   always_ff @(posedge clock) begin
      if (reset) begin
         peak_ff <= SAMPLE_BITS'(16'd255);
         thr8_ff <= '0;
         str8_ff <= '0;
         wide_ff <= 1'b0;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_SAMPLE_PEAK: peak_ff <= csr_write_data[SAMPLE_BITS-1:0];
            CSR_THRESHOLD:   thr8_ff <= csr_write_data[7:0];
            CSR_STRENGTH:    str8_ff <= csr_write_data[7:0];
            CSR_WIDE_CURVE:  wide_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign mag = req_pixel_difference[16] ? MAG_W'(-req_pixel_difference)
                                         : MAG_W'(req_pixel_difference);

   rcdw_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_mag    (mag),
      .peak      (PEAK_W'(peak_ff)),
      .thr8      (thr8_ff),
      .str8      (str8_ff),
      .wide      (wide_ff),
      .out_valid (sc_valid),
      .out_num   (sc_num),
      .out_den   (sc_den),
      .out_side  (sc_side)
   );

   rcdw_div u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (sc_valid),
      .in_num    (sc_num),
      .in_den    (sc_den),
      .in_side   (sc_side),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_side  (div_side)
   );

   rcdw_cos u_cos (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (div_valid),
      .in_phase  (div_quo),
      .in_side   (div_side),
      .out_valid (cos_valid),
      .out_q     (cos_q),
      .out_side  (cos_side)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         fin_vld_ff   <= cos_valid;
         rsp_valid_ff <= fin_vld_ff;
      end
   end

   always_comb begin
      curve = fin_prod_ff[40:24];
      if (fin_side_ff.thr_zero) begin
         wsel = fin_side_ff.mag_zero ? 17'(fin_side_ff.str) : '0;
      end else if (fin_side_ff.in_range) begin
         wsel = curve;
      end else begin
         wsel = '0;
      end
      rsp_weight_in = (wsel > 17'(fin_side_ff.peak)) ? fin_side_ff.peak : wsel[15:0];
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         fin_side_ff   <= cos_side;
         fin_prod_ff   <= 41'(cos_side.str >> 1) * 41'(cos_q);
         rsp_weight_ff <= rsp_weight_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_weight = rsp_weight_ff;

   a_out_of_range_zero: assert property (@(posedge clock) disable iff (reset)
      advance && fin_vld_ff && !fin_side_ff.in_range |=> rsp_weight == '0)
      else $error("weight not zero beyond threshold");

   a_phase_bound: assert property (@(posedge clock) disable iff (reset)
      div_valid && div_side.in_range && !div_side.thr_zero |-> div_quo <= Q24_ONE)
      else $error("phase above one");

   a_curve_bound: assert property (@(posedge clock) disable iff (reset)
      cos_valid |-> cos_q <= 26'(Q24_ONE) + 26'(Q24_ONE))
      else $error("raised cosine above two");

endmodule
`default_nettype wire

/* test/tb_raised_cosine_diff_weight_core.sv */
`default_nettype none
module tb_raised_cosine_diff_weight_core;
   timeunit 1ns;
   timeprecision 1ps;
   import rcdw_pkg::*;

   localparam int LATENCY = 53;
   localparam longint CYCLE_LIMIT = 400000;
   localparam longint Q24 = 64'd16777216;
   localparam longint Q30 = 64'd1073741824;
   localparam longint PIQ30 = 64'd3373259426;

   class weight_scoreboard;
      logic [15:0] peak_r;
      logic [7:0]  thr8_r;
      logic [7:0]  str8_r;
      logic        wide_r;
      logic [15:0] weights_due[$];

      function new();
         peak_r = 16'd255;
         thr8_r = '0;
         str8_r = '0;
         wide_r = 1'b0;
      endfunction

      function void set_reg(logic [1:0] idx, logic [15:0] data);
         case (idx)
            CSR_SAMPLE_PEAK: peak_r = data;
            CSR_THRESHOLD:   thr8_r = data[7:0];
            CSR_STRENGTH:    str8_r = data[7:0];
            CSR_WIDE_CURVE:  wide_r = data[0];
            default: ;
         endcase
      endfunction

      function longint cos_fix(longint theta);
         longint t, r, sub;
         int k[6];
         k = '{132, 90, 56, 30, 12, 2};
         t = (theta * theta) >>> 30;
         r = Q30;
         for (int i = 0; i < 6; i++) begin
            sub = ((t * r) >>> 30) / k[i];
            r = (sub > Q30) ? 0 : Q30 - sub;
         end
         return r;
      endfunction

      function logic [15:0] weight_of(logic signed [16:0] d);
         longint mag, thr, str, num, den, p, y, c, q, w, half;
         mag = (d < 0) ? -longint'(d) : longint'(d);
         thr = (longint'(thr8_r) * peak_r + 127) / 255;
         str = (longint'(str8_r) * peak_r + 127) / 255;
         w = 0;
         if (thr == 0) begin
            w = (mag == 0) ? str : 0;
         end else if (mag <= thr) begin
            half = str / 2;
            num = wide_r ? mag * mag : mag;
            den = wide_r ? thr * thr : thr;
            p = (num << 24) / den;
            if (p > Q24) p = Q24;
            y = (p <= Q24 / 2) ? p : Q24 - p;
            c = cos_fix((y * PIQ30) >>> 24) >>> 6;
            if (c > Q24) c = Q24;
            q = (p <= Q24 / 2) ? Q24 + c : Q24 - c;
            w = (half * q) >>> 24;
         end
         if (w > peak_r) w = peak_r;
         return w[15:0];
      endfunction

      function void note_difference(logic signed [16:0] d);
         weights_due.push_back(weight_of(d));
      endfunction

      function string check_weight(logic [15:0] got);
         logic [15:0] want;
         if (weights_due.size() == 0) begin
            return $sformatf("unexpected weight %0d", got);
         end
         want = weights_due.pop_front();
         if (got !== want) begin
            return $sformatf("weight %0d, want %0d", got, want);
         end
         return "";
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic signed [16:0] req_pixel_difference = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [15:0] rsp_weight;
   logic csr_write_enable = 1'b0;
   logic [1:0] csr_index = '0;
   logic [15:0] csr_write_data = '0;

   weight_scoreboard sb = new();
   longint cycles = 0;
   bit hold_rsp = 1'b0;
   int fail_count = 0;
   string rsp_msg;

   raised_cosine_diff_weight_core u_dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic report(string what);
      $display("ERROR: %s", what);
      fail_count++;
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         rsp_msg = sb.check_weight(rsp_weight);
         if (rsp_msg != "") report(rsp_msg);
      end
   end

   int stall_mode = 0;
   always @(posedge clock) begin
      if (hold_rsp) rsp_ready <= 1'b0;
      else case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 1) != 0);
      endcase
      if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 2);
   end

   task automatic write_reg(logic [1:0] idx, logic [15:0] data);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= data;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      sb.set_reg(idx, data);
      @(posedge clock);
   endtask

   task automatic drain();
      while (sb.weights_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 5) @(posedge clock);
   endtask

   int burst_left = 0;
   task automatic send(logic signed [16:0] d);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(0, 6);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      burst_left--;
      req_valid <= 1'b1;
      req_pixel_difference <= d;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_difference(d);
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [16:0] pick_diff();
      longint thr;
      int m;
      thr = (longint'(sb.thr8_r) * sb.peak_r + 127) / 255;
      case ($urandom_range(0, 4))
         0: return 17'($urandom);
         1: return 17'sd0;
         default: begin
            m = $urandom_range(0, int'(thr) + 2);
            if (m > 65535) m = 65535;
            return $urandom_range(0, 1) ? 17'(m) : -17'(m);
         end
      endcase
   endfunction

   initial begin
      logic signed [16:0] dirs[$];
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      dirs = '{17'sd0, 17'sd1, -17'sd1, 17'sd65535, -17'sd65535, -17'sd65536};
      foreach (dirs[i]) send(dirs[i]);
      idle_sender();
      drain();
      write_reg(CSR_THRESHOLD, 16'd20);
      write_reg(CSR_STRENGTH, 16'd255);
      write_reg(CSR_WIDE_CURVE, 16'd0);
      dirs = '{17'sd0, 17'sd10, -17'sd10, 17'sd19, 17'sd20, 17'sd21, -17'sd20, 17'sd5};
      foreach (dirs[i]) send(dirs[i]);
      idle_sender();
      drain();
      write_reg(CSR_WIDE_CURVE, 16'd1);
      foreach (dirs[i]) send(dirs[i]);
      idle_sender();
      drain();
      write_reg(CSR_SAMPLE_PEAK, 16'd65535);
      write_reg(CSR_THRESHOLD, 16'd255);
      dirs = '{17'sd0, 17'sd65535, -17'sd65535, 17'sd32768, -17'sd65536, 17'sd1};
      foreach (dirs[i]) send(dirs[i]);
      idle_sender();
      drain();
      for (int phase = 0; phase < 8; phase++) begin
         write_reg(CSR_SAMPLE_PEAK, phase == 0 ? 16'd1 : phase == 1 ? 16'd65535 :
                   phase == 2 ? 16'd0 : 16'($urandom_range(1, 65535)));
         write_reg(CSR_THRESHOLD, phase == 3 ? 16'd0 : phase == 4 ? 16'd255 :
                   16'($urandom_range(0, 255)));
         write_reg(CSR_STRENGTH, phase == 5 ? 16'd0 : phase == 4 ? 16'd255 :
                   16'($urandom_range(0, 255)));
         write_reg(CSR_WIDE_CURVE, 16'($urandom_range(0, 1)));
         if (phase == 2) begin
            fork
               begin
                  hold_rsp = 1'b1;
                  repeat (200) @(posedge clock);
                  hold_rsp = 1'b0;
               end
            join_none
         end
         for (int n = 0; n < (phase == 2 ? 80 : 50); n++) send(pick_diff());
         idle_sender();
         drain();
      end
      if (sb.weights_due.size() != 0) begin
         report($sformatf("%0d weights never came", sb.weights_due.size()));
      end
      if (fail_count == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
`default_nettype wire
